// ===== hdl/assert_macros.svh =====
// assertion macros used by the checker file
// clocked properties with and without a reset guard
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked only while reset is low
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked at every edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/fl_ptm_pkg.sv =====
// shared types, constants and helpers of the page table manager
// no dependencies
`timescale 1ns / 1ps

package fl_ptm_pkg;

  // table store geometry
  localparam int TABLE_FRAMES = 16;
  localparam int IDX_W        = 9;
  localparam int ENTRIES      = 512;
  localparam int FRAME_W      = $clog2(TABLE_FRAMES);
  localparam int NFF_W        = $clog2(TABLE_FRAMES + 1);
  localparam int ADDR_W       = FRAME_W + IDX_W;
  localparam int DEPTH        = TABLE_FRAMES * ENTRIES;
  localparam int ENTRY_W      = 64;
  localparam int PAGE_SHIFT   = 12;

  // field widths
  localparam int MODE_W   = 2;
  localparam int VA_W     = 48;
  localparam int PA_W     = 52;
  localparam int FLAGS_W  = 64;
  localparam int XLAT_W   = 64;
  localparam int STATUS_W = 2;

  // stream word widths
  localparam int S_TDATA_W = 168;
  localparam int M_TDATA_W = 72;

  // entry bits
  localparam logic [ENTRY_W-1:0] BIT_PRESENT = 64'h1;
  localparam logic [ENTRY_W-1:0] BIT_WRITE   = 64'h2;

  localparam logic [1:0] LEAF_LVL = 2'd3;

  // operation codes
  localparam logic [MODE_W-1:0] MODE_MAP   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_UNMAP = 2'd1;
  localparam logic [MODE_W-1:0] MODE_XLATE = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] STAT_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NOTMAP  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_NOFRAME = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [VA_W-1:0]    virt_addr;
    logic [PA_W-1:0]    phys_addr;
    logic [FLAGS_W-1:0] page_flags;
  } req_t;

  typedef struct packed {
    logic [XLAT_W-1:0]   translated;
    logic [STATUS_W-1:0] status;
    logic                tlb_invalidate;
  } res_t;

  // table index of one walk level
  function automatic logic [IDX_W-1:0] lvl_index(input logic [VA_W-1:0] va,
                                                 input logic [1:0] lvl);
    logic [IDX_W-1:0] idx;
    case (lvl)
      2'd0:    idx = va[47:39];
      2'd1:    idx = va[38:30];
      2'd2:    idx = va[29:21];
      default: idx = va[20:12];
    endcase
    return idx;
  endfunction

endpackage

// ===== hdl/fl_ptm_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module fl_ptm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/fl_ptm_walker.sv =====
// table walk sequencer: clearing pass, walk, table creation and leaf update
// depends on fl_ptm_pkg and fl_ptm_ram
`timescale 1ns / 1ps

module fl_ptm_walker (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  fl_ptm_pkg::req_t in_req,
  output logic             res_valid,
  input  logic             res_ready,
  output fl_ptm_pkg::res_t res
);
  import fl_ptm_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_RD, S_CHK, S_WR, S_FIN
  } state_t;

  state_t             state;
  logic [ADDR_W-1:0]  clr_addr;
  logic [1:0]         lvl;
  logic [FRAME_W-1:0] frame;
  logic [NFF_W-1:0]   nff;
  req_t               req;

  logic               we;
  logic [ADDR_W-1:0]  waddr;
  logic [ENTRY_W-1:0] wdata;
  logic               re;
  logic [ENTRY_W-1:0] rdata;

  logic [ADDR_W-1:0]  acc_addr;
  logic               child_ok;
  logic [FRAME_W-1:0] child;
  logic [1:0]         needed;
  logic               frames_short;
  logic [ENTRY_W-1:0] leaf_entry;
  logic [ENTRY_W-1:0] ptr_entry;

  // address of the entry at the current level
  assign acc_addr = {frame, lvl_index(req.virt_addr, lvl)};

  // upper-level entry decode
  assign child_ok = rdata[0] &&
                    (rdata[ENTRY_W-1:PAGE_SHIFT] < (ENTRY_W-PAGE_SHIFT)'(TABLE_FRAMES));
  assign child    = rdata[PAGE_SHIFT +: FRAME_W];

  // frames still to create from the level that was found missing
  assign needed       = LEAF_LVL - lvl;
  assign frames_short = ({1'b0, nff} + (NFF_W+1)'(needed)) > (NFF_W+1)'(TABLE_FRAMES);

  // entries written by map
  assign leaf_entry = ENTRY_W'({req.phys_addr[PA_W-1:PAGE_SHIFT], 12'h000})
                    | req.page_flags | BIT_PRESENT;
  assign ptr_entry  = (ENTRY_W'(nff) << PAGE_SHIFT) | BIT_WRITE | BIT_PRESENT;

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_FIN);

  // memory port control
  always_comb begin
    we    = 1'b0;
    waddr = acc_addr;
    wdata = '0;
    re    = 1'b0;
    unique case (state)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_addr;
      end
      S_RD: re = 1'b1;
      S_CHK: begin
        if (lvl == LEAF_LVL && req.mode == MODE_UNMAP) begin
          we = 1'b1;
        end
      end
      S_WR: begin
        we    = 1'b1;
        wdata = (lvl == LEAF_LVL) ? leaf_entry : ptr_entry;
      end
      default: ;
    endcase
  end

  fl_ptm_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(acc_addr),
    .rdata(rdata)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      nff      <= NFF_W'(1);
      lvl      <= '0;
      frame    <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == ADDR_W'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            req   <= in_req;
            lvl   <= '0;
            frame <= '0;
            res   <= '0;
            if (in_req.mode == MODE_MAP || in_req.mode == MODE_UNMAP ||
                in_req.mode == MODE_XLATE) begin
              state <= S_RD;
            end else begin
              state <= S_FIN;
            end
          end
        end
        S_RD: state <= S_CHK;
        S_CHK: begin
          if (lvl != LEAF_LVL) begin
            if (child_ok) begin
              frame <= child;
              lvl   <= lvl + 1'b1;
              // map does not need the old leaf
              state <= (req.mode == MODE_MAP && lvl == 2'd2) ? S_WR : S_RD;
            end else if (req.mode == MODE_MAP) begin
              if (frames_short) begin
                res.status <= STAT_NOFRAME;
                state      <= S_FIN;
              end else begin
                state <= S_WR;
              end
            end else begin
              res.status <= STAT_NOTMAP;
              state      <= S_FIN;
            end
          end else if (req.mode == MODE_UNMAP) begin
            // leaf cleared by the write port this cycle
            res.status         <= rdata[0] ? STAT_DONE : STAT_NOTMAP;
            res.tlb_invalidate <= (rdata != '0);
            state              <= S_FIN;
          end else begin
            if (rdata[0]) begin
              res.translated <= {rdata[ENTRY_W-1:PAGE_SHIFT],
                                 req.virt_addr[PAGE_SHIFT-1:0]};
              res.status     <= STAT_DONE;
            end else begin
              res.status <= STAT_NOTMAP;
            end
            state <= S_FIN;
          end
        end
        S_WR: begin
          if (lvl != LEAF_LVL) begin
            // new table frames are already zero from the clearing pass
            frame <= nff[FRAME_W-1:0];
            nff   <= nff + 1'b1;
            lvl   <= lvl + 1'b1;
          end else begin
            res.status         <= STAT_DONE;
            res.tlb_invalidate <= 1'b1;
            state              <= S_FIN;
          end
        end
        S_FIN: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/four_level_page_table_manager_top.sv =====
// four-level page table manager: stream ports around the walk sequencer
// and a result output register; depends on fl_ptm_pkg and fl_ptm_walker
//
// s_* takes one request word: mode in s_tuser selects map (0), unmap (1)
// or translate (2); s_tdata carries the addresses and flags. m_* gives one
// result word per request: status in m_tuser, translated address and tlb
// invalidate flag in m_tdata. One request is in flight at a time.
// Each level takes a read state and a check state on the single memory
// port, and a finish state precedes m_tvalid. A map walks down to the
// first missing level, or to the leaf without reading it, then writes one
// pointer entry per created table and the leaf entry before it finishes;
// a missing level ends a translate or unmap, or a map short of frames, at
// its check. s_tready returns in the same cycle as the result enters the
// output register, so one walk ends before the next request is taken.
// After reset every entry of the table memory is swept to zero, with
// s_tready low. A finished result sits in the output register until
// m_tready; the next request is accepted meanwhile and holds in the
// sequencer if the register is still full when it completes.
`timescale 1ns / 1ps

module four_level_page_table_manager_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // virt_addr[47:0], phys_addr[99:48], page_flags[163:100], zero fill
  input  logic [fl_ptm_pkg::S_TDATA_W-1:0] s_tdata,
  // mode[1:0]
  input  logic [fl_ptm_pkg::MODE_W-1:0]    s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // translated[63:0], tlb_invalidate[64], zero fill
  output logic [fl_ptm_pkg::M_TDATA_W-1:0] m_tdata,
  // status[1:0]
  output logic [fl_ptm_pkg::STATUS_W-1:0]  m_tuser
);
  import fl_ptm_pkg::*;

  req_t in_req;
  res_t res;
  logic res_valid;
  logic res_ready;

  // unpack request word
  assign in_req.mode       = s_tuser;
  assign in_req.virt_addr  = s_tdata[VA_W-1:0];
  assign in_req.phys_addr  = s_tdata[VA_W +: PA_W];
  assign in_req.page_flags = s_tdata[VA_W+PA_W +: FLAGS_W];

  fl_ptm_walker u_walker (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_req   (in_req),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  assign res_ready = !m_tvalid || m_tready;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {(M_TDATA_W-XLAT_W-1)'(0), res.tlb_invalidate, res.translated};
        m_tuser  <= res.status;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

// ===== hdl/fl_ptm_checker.sv =====
// port-level checks of the page table manager, bound to the top level
// depends on fl_ptm_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fl_ptm_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tvalid,
  input logic                             s_tready,
  input logic [fl_ptm_pkg::S_TDATA_W-1:0] s_tdata,
  input logic [fl_ptm_pkg::MODE_W-1:0]    s_tuser,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [fl_ptm_pkg::M_TDATA_W-1:0] m_tdata,
  input logic [fl_ptm_pkg::STATUS_W-1:0]  m_tuser
);
  import fl_ptm_pkg::*;

  // stalled result word holds
  `ASSERT_CLK(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result word changed while stalled")

  // reset starts the clearing pass with nothing pending
  `ASSERT_ALWAYS(a_reset_quiet, clk, rst |=> !s_tready && !m_tvalid, "ports active right after reset")

  // one request at a time
  `ASSERT_CLK(a_one_in_flight, clk, rst, s_tvalid && s_tready |=> !s_tready, "request accepted while another is in flight")

  // a failing status returns no address
  `ASSERT_CLK(a_xlat_zero, clk, rst, m_tvalid && m_tuser != STAT_DONE |-> m_tdata[XLAT_W-1:0] == '0, "address returned with failing status")

  // frame exhaustion raises no tlb invalidate
  `ASSERT_CLK(a_noframe, clk, rst, m_tvalid && m_tuser == STAT_NOFRAME |-> !m_tdata[XLAT_W], "invalidate flagged on frame exhaustion")

endmodule

bind four_level_page_table_manager_top fl_ptm_checker u_checker (.*);
